// File: sv/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types, status codes and lead byte decode for the UTF-8 stream decoder
// ----------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEAD = 2'd1;
    localparam logic [1:0] ST_BAD_CONT = 2'd2;
    localparam logic [1:0] ST_TRUNC    = 2'd3;

    // default continuation window and reset replacement code
    localparam logic [7:0]  CONT_LOW   = 8'h80;
    localparam logic [7:0]  CONT_HIGH  = 8'hbf;
    localparam logic [20:0] REPL_RESET = 21'h00fffd;

    // one result item
    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  width;
        logic [1:0]  status;
        logic        last_of_run;
    } t_result;

    // sequence state carried between bytes
    typedef struct packed {
        logic [20:0] acc;
        logic [2:0]  expected;
        logic [2:0]  seen;
        logic [7:0]  second_low;
        logic [7:0]  second_high;
    } t_dec_state;

    // up to two results produced by one byte
    typedef struct packed {
        logic    push0;
        logic    push1;
        t_result res0;
        t_result res1;
    } t_push;

    // outcome of decoding a byte as a lead byte
    typedef struct packed {
        logic       emit;
        t_result    res;
        t_dec_state st;
    } t_lead;

    function automatic t_dec_state idle_state();
        t_dec_state s;
        s.acc         = '0;
        s.expected    = 3'd0;
        s.seen        = 3'd0;
        s.second_low  = CONT_LOW;
        s.second_high = CONT_HIGH;
        return s;
    endfunction

    // decode a byte as a lead byte from the idle state
    function automatic t_lead lead_decode(input logic [7:0] b, input logic eoi,
                                          input logic [20:0] repl);
        t_lead r;
        r.emit = 1'b0;
        r.res  = '{code_point: '0, width: 3'd0, status: ST_OK, last_of_run: 1'b1};
        r.st   = idle_state();
        if (b < 8'h80) begin
            r.emit           = 1'b1;
            r.res.code_point = {13'd0, b};
            r.res.width      = 3'd1;
        end else if (b inside {[8'hc2:8'hdf], [8'he0:8'hef], [8'hf0:8'hf4]}) begin
            r.st.seen = 3'd1;
            if (b <= 8'hdf) begin
                r.st.acc      = {16'd0, b[4:0]};
                r.st.expected = 3'd2;
            end else if (b <= 8'hef) begin
                r.st.acc      = {17'd0, b[3:0]};
                r.st.expected = 3'd3;
                if (b == 8'he0) r.st.second_low  = 8'ha0;
                if (b == 8'hed) r.st.second_high = 8'h9f;
            end else begin
                r.st.acc      = {18'd0, b[2:0]};
                r.st.expected = 3'd4;
                if (b == 8'hf0) r.st.second_low  = 8'h90;
                if (b == 8'hf4) r.st.second_high = 8'h8f;
            end
            // end of input right after a multi-byte lead
            if (eoi) begin
                r.emit       = 1'b1;
                r.res.status = ST_TRUNC;
                r.st         = idle_state();
            end
        end else begin
            r.emit           = 1'b1;
            r.res.code_point = repl;
            r.res.width      = 3'd1;
            r.res.status     = ST_BAD_LEAD;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/u8d_if.sv
// ----------------------------------------------------------------------------
// u8d_if
// Valid/ready channel interfaces for bytes in, results out and configuration
// ----------------------------------------------------------------------------
`default_nettype none

interface u8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;
    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface u8d_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [2:0]  width;
    logic [1:0]  status;
    logic        last_of_run;
    modport source (output valid, output code_point, output width, output status,
                    output last_of_run, input ready);
    modport sink   (input valid, input code_point, input width, input status,
                    input last_of_run, output ready);
endinterface

interface u8d_cfg_if;
    logic        valid;
    logic        ready;
    logic [20:0] replacement_code;
    modport source (output valid, output replacement_code, input ready);
    modport sink   (input valid, input replacement_code, output ready);
endinterface

`default_nettype wire

// File: sv/u8d_core.sv
// ----------------------------------------------------------------------------
// u8d_core
// Input register, sequence state and single-pass decode of one byte
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    u8d_in_if.sink              i_in,
    input  wire logic [20:0]    i_repl,
    input  wire logic           i_can_take,
    output u8d_pkg::t_push      o_push
);

    logic                r_in_valid;
    logic [7:0]          r_byte;
    logic                r_eoi;
    u8d_pkg::t_dec_state r_state;
    u8d_pkg::t_dec_state n_state;
    u8d_pkg::t_lead      lead;
    u8d_pkg::t_push      push;
    logic [7:0]          lo;
    logic [7:0]          hi;
    logic [20:0]         acc_next;
    logic [2:0]          seen_next;
    logic                fire;

    // decode the registered byte against the current sequence state
    always_comb begin
        lead      = u8d_pkg::lead_decode(r_byte, r_eoi, i_repl);
        lo        = (r_state.seen == 3'd1) ? r_state.second_low  : u8d_pkg::CONT_LOW;
        hi        = (r_state.seen == 3'd1) ? r_state.second_high : u8d_pkg::CONT_HIGH;
        acc_next  = {r_state.acc[14:0], r_byte[5:0]};
        seen_next = r_state.seen + 3'd1;
        n_state   = r_state;
        push      = '0;
        if (r_state.expected == 3'd0) begin
            n_state    = lead.st;
            push.push0 = lead.emit;
            push.res0  = lead.res;
        end else if (r_byte < lo || r_byte > hi) begin
            // broken sequence, the byte restarts as a lead
            n_state    = lead.st;
            push.push0 = 1'b1;
            push.res0  = '{code_point: '0, width: 3'd0,
                           status: u8d_pkg::ST_BAD_CONT, last_of_run: !lead.emit};
            push.push1 = lead.emit;
            push.res1  = lead.res;
        end else if (seen_next >= r_state.expected) begin
            n_state    = u8d_pkg::idle_state();
            push.push0 = 1'b1;
            push.res0  = '{code_point: acc_next, width: r_state.expected,
                           status: u8d_pkg::ST_OK, last_of_run: 1'b1};
        end else if (r_eoi) begin
            n_state    = u8d_pkg::idle_state();
            push.push0 = 1'b1;
            push.res0  = '{code_point: '0, width: 3'd0,
                           status: u8d_pkg::ST_TRUNC, last_of_run: 1'b1};
        end else begin
            n_state.acc  = acc_next;
            n_state.seen = seen_next;
        end
    end

    // a byte with no result never waits for the output side
    assign fire          = r_in_valid && (!push.push0 || i_can_take);
    assign i_in.ready    = !r_in_valid || fire;
    assign o_push.push0  = fire && push.push0;
    assign o_push.push1  = fire && push.push1;
    assign o_push.res0   = push.res0;
    assign o_push.res1   = push.res1;

    // input register and sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= u8d_pkg::idle_state();
        end else begin
            if (i_in.ready) r_in_valid <= i_in.valid;
            if (fire)       r_state    <= n_state;
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_byte <= i_in.data_byte;
            r_eoi  <= i_in.end_of_input;
        end
    end

    // end of input always leaves the decoder idle
    a_eoi_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_eoi |=> r_state.expected == 3'd0)
        else $error("decoder not idle after end of input");

    // a good code point always carries a width
    a_ok_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.push0 && o_push.res0.status == u8d_pkg::ST_OK |-> o_push.res0.width != 3'd0)
        else $error("ok result with zero width");

endmodule

`default_nettype wire

// File: sv/u8d_out_buf.sv
// ----------------------------------------------------------------------------
// u8d_out_buf
// Result register with one spare slot for the second result of a byte
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_out_buf (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire u8d_pkg::t_push i_push,
    output logic                o_can_take,
    u8d_out_if.source           o_out
);

    logic             r_out_valid;
    logic             r_pend_valid;
    u8d_pkg::t_result r_out;
    u8d_pkg::t_result r_pend;
    logic             out_free;

    // the slot is free when empty or its request goes this cycle
    assign out_free   = !r_out_valid || o_out.ready;
    assign o_can_take = out_free && !r_pend_valid;

    assign o_out.valid       = r_out_valid;
    assign o_out.code_point  = r_out.code_point;
    assign o_out.width       = r_out.width;
    assign o_out.status      = r_out.status;
    assign o_out.last_of_run = r_out.last_of_run;

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (i_push.push0) begin
            r_out_valid  <= 1'b1;
            r_pend_valid <= i_push.push1;
        end else if (out_free) begin
            r_out_valid  <= r_pend_valid;
            r_pend_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_out  <= i_push.res0;
            r_pend <= i_push.res1;
        end else if (out_free) begin
            r_out  <= r_pend;
        end
    end

    // the spare slot only holds a result behind the output slot
    a_pend_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_out_valid)
        else $error("spare result without an output result");

    // a second result only comes with a first
    a_push_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push1 |-> i_push.push0 && !r_pend_valid)
        else $error("second result pushed out of order");

endmodule

`default_nettype wire

// File: sv/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder with validation of lead and continuation bytes
//
//   channel   dir   payload                                       request
//   i_in      in    data_byte[7:0], end_of_input                  one byte
//   o_out     out   code_point[20:0], width[2:0], status[1:0],    one result
//                   last_of_run
//   i_cfg     in    replacement_code[20:0]                        register write
//
// One byte accepted per cycle unless the output stalls, which backs up into
// the input register. A byte with two results stalls later bytes that have
// results while the spare slot drains. Throughput is set by the single
// output slot. Reset is synchronous, active low; it clears the sequence
// state and restores replacement_code to 0xfffd.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    u8d_in_if.sink     i_in,
    u8d_out_if.source  o_out,
    u8d_cfg_if.sink    i_cfg
);

    logic [20:0]    r_repl;
    logic           can_take;
    u8d_pkg::t_push push;

    // configuration register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repl <= u8d_pkg::REPL_RESET;
        end else if (i_cfg.valid) begin
            r_repl <= i_cfg.replacement_code;
        end
    end

    // byte decode
    u8d_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_repl     (r_repl),
        .i_can_take (can_take),
        .o_push     (push)
    );

    // result buffering
    u8d_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_can_take (can_take),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire
